// ===== src/kffpa_pkg.sv =====
// Package for the keyed first-fit port allocator.
// Holds sizes, codes, the sequencer state type and the slot table command struct.
// No dependencies.
package kffpa_pkg;

   localparam int MAX_PORTS = 128;
   localparam int IDX_W = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
   localparam int NUM_W = $clog2(MAX_PORTS + 1);
   localparam int CNT_W = (NUM_W > 8) ? NUM_W : 8;
   localparam int PORT_W = 16;
   localparam int ID_W = 32;
   localparam int CSR_IDX_W = 1;

   localparam logic [PORT_W-1:0] RESET_PORT_LOW = 16'd8201;
   localparam logic [PORT_W-1:0] RESET_PORT_HIGH = 16'd8299;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_RELEASE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_PORT_LOW = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PORT_HIGH = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ALLOC,
      ST_REL_READ,
      ST_REL_CHK,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic             clear_all;
      logic             set;
      logic             clr;
      logic [IDX_W-1:0] wr_idx;
      logic [IDX_W-1:0] rd_idx;
      logic [ID_W-1:0]  owner;
   } tbl_cmd_type;

endpackage

// ===== src/kffpa_slot_table.sv =====
// Slot table: used bits in flip-flops and the owner id memory.
// One write and one registered read per cycle. Depends on kffpa_pkg.
module kffpa_slot_table (
   input  logic                       clock,
   input  logic                       reset,
   input  kffpa_pkg::tbl_cmd_type     cmd,
   output logic                       rd_used,
   output logic [kffpa_pkg::ID_W-1:0] rd_owner
);

   logic [kffpa_pkg::MAX_PORTS-1:0] used_ff;
   logic [kffpa_pkg::ID_W-1:0]      owner_mem [kffpa_pkg::MAX_PORTS];
   logic                            rd_used_ff;
   logic [kffpa_pkg::ID_W-1:0]      rd_owner_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_all) begin
         used_ff <= '0;
      end else begin
         if (cmd.set) begin
            used_ff[cmd.wr_idx] <= 1'b1;
         end
         if (cmd.clr) begin
            used_ff[cmd.wr_idx] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.set) begin
         owner_mem[cmd.wr_idx] <= cmd.owner;
      end
      rd_owner_ff <= owner_mem[cmd.rd_idx];
      rd_used_ff <= used_ff[cmd.rd_idx];
   end

   assign rd_used = rd_used_ff;
   assign rd_owner = rd_owner_ff;

endmodule

// ===== src/kffpa_ctl.sv =====
// Sequencer with the owner compare unit, range registers and use count.
// Drives the slot table and holds the result register. Depends on kffpa_pkg.
module kffpa_ctl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_mode,
   input  logic [kffpa_pkg::ID_W-1:0]        req_requester_id,
   input  logic [kffpa_pkg::PORT_W-1:0]      req_release_port,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [kffpa_pkg::PORT_W-1:0]      rsp_granted_port,
   output logic                              rsp_ok,
   output logic                              rsp_reused,
   output logic [7:0]                        rsp_ports_in_use,
   input  logic                              csr_we,
   input  logic [kffpa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [kffpa_pkg::PORT_W-1:0]      csr_wdata,
   output kffpa_pkg::tbl_cmd_type            tbl_cmd,
   input  logic                              tbl_used,
   input  logic [kffpa_pkg::ID_W-1:0]        tbl_owner
);

   localparam int IDX_W = kffpa_pkg::IDX_W;
   localparam int NUM_W = kffpa_pkg::NUM_W;
   localparam int CNT_W = kffpa_pkg::CNT_W;
   localparam int PORT_W = kffpa_pkg::PORT_W;
   localparam int ID_W = kffpa_pkg::ID_W;

   kffpa_pkg::state_type state_ff, state_in;

   logic [PORT_W-1:0] port_low_ff, port_high_ff;
   logic [PORT_W-1:0] lo_ff, lo_in;
   logic [NUM_W-1:0]  n_ff, n_in;
   logic [ID_W-1:0]   req_id_ff, req_id_in;
   logic [PORT_W-1:0] rel_port_ff, rel_port_in;
   logic [NUM_W-1:0]  issue_ff, issue_in;
   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  pend_idx_ff, pend_idx_in;
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic              rel_hit_ff, rel_hit_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PORT_W-1:0] rsp_port_ff, rsp_port_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic              rsp_reused_ff, rsp_reused_in;

   logic [PORT_W-1:0] eff_lo;
   logic [PORT_W:0]   span;
   logic [NUM_W-1:0]  n_calc;
   logic [PORT_W:0]   rel_diff;
   logic              rel_in_range;
   logic              hit;
   logic              scan_done;
   logic              accept;

   assign accept = req_valid && (state_ff == kffpa_pkg::ST_IDLE);
   assign req_ready = (state_ff == kffpa_pkg::ST_IDLE);

   always_comb begin
      eff_lo = (port_low_ff == '0) ? PORT_W'(1) : port_low_ff;
      span = {1'b0, port_high_ff} - {1'b0, eff_lo};
      if (port_high_ff < eff_lo) begin
         n_calc = '0;
      end else if (span >= (PORT_W+1)'(kffpa_pkg::MAX_PORTS)) begin
         n_calc = NUM_W'(kffpa_pkg::MAX_PORTS);
      end else begin
         n_calc = NUM_W'(span + (PORT_W+1)'(1));
      end
      rel_diff = {1'b0, rel_port_ff} - {1'b0, lo_ff};
      rel_in_range = (rel_port_ff >= lo_ff) && (rel_diff < (PORT_W+1)'(n_ff));
      hit = pend_ff && tbl_used && (tbl_owner == req_id_ff);
      scan_done = !pend_ff && (issue_ff >= n_ff);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kffpa_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_mode == kffpa_pkg::MODE_RELEASE) ?
                          kffpa_pkg::ST_REL_READ : kffpa_pkg::ST_SCAN;
            end
         end
         kffpa_pkg::ST_SCAN: begin
            if (hit) begin
               state_in = kffpa_pkg::ST_RESP;
            end else if (scan_done) begin
               state_in = found_ff ? kffpa_pkg::ST_ALLOC : kffpa_pkg::ST_RESP;
            end
         end
         kffpa_pkg::ST_ALLOC:    state_in = kffpa_pkg::ST_RESP;
         kffpa_pkg::ST_REL_READ: state_in = kffpa_pkg::ST_REL_CHK;
         kffpa_pkg::ST_REL_CHK:  state_in = kffpa_pkg::ST_RESP;
         kffpa_pkg::ST_RESP: begin
            if (rsp_ready) begin
               state_in = kffpa_pkg::ST_IDLE;
            end
         end
         default: state_in = kffpa_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      lo_in = lo_ff;
      n_in = n_ff;
      req_id_in = req_id_ff;
      rel_port_in = rel_port_ff;
      issue_in = issue_ff;
      pend_in = 1'b0;
      pend_idx_in = pend_idx_ff;
      found_in = found_ff;
      free_idx_in = free_idx_ff;
      rel_hit_in = rel_hit_ff;
      count_in = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_port_in = rsp_port_ff;
      rsp_ok_in = rsp_ok_ff;
      rsp_reused_in = rsp_reused_ff;
      tbl_cmd.clear_all = 1'b0;
      tbl_cmd.set = 1'b0;
      tbl_cmd.clr = 1'b0;
      tbl_cmd.wr_idx = free_idx_ff;
      tbl_cmd.rd_idx = issue_ff[IDX_W-1:0];
      tbl_cmd.owner = req_id_ff;
      unique case (state_ff)
         kffpa_pkg::ST_IDLE: begin
            if (accept) begin
               lo_in = eff_lo;
               n_in = n_calc;
               req_id_in = req_requester_id;
               rel_port_in = req_release_port;
               issue_in = '0;
               found_in = 1'b0;
            end
         end
         kffpa_pkg::ST_SCAN: begin
            if (issue_ff < n_ff) begin
               pend_in = 1'b1;
               pend_idx_in = issue_ff[IDX_W-1:0];
               issue_in = issue_ff + NUM_W'(1);
            end
            if (pend_ff && !tbl_used && !found_ff) begin
               found_in = 1'b1;
               free_idx_in = pend_idx_ff;
            end
            if (hit) begin
               rsp_valid_in = 1'b1;
               rsp_port_in = lo_ff + PORT_W'(pend_idx_ff);
               rsp_ok_in = 1'b1;
               rsp_reused_in = 1'b1;
            end else if (scan_done && !found_ff) begin
               rsp_valid_in = 1'b1;
               rsp_port_in = '0;
               rsp_ok_in = 1'b0;
               rsp_reused_in = 1'b0;
            end
         end
         kffpa_pkg::ST_ALLOC: begin
            tbl_cmd.set = 1'b1;
            count_in = count_ff + CNT_W'(1);
            rsp_valid_in = 1'b1;
            rsp_port_in = lo_ff + PORT_W'(free_idx_ff);
            rsp_ok_in = 1'b1;
            rsp_reused_in = 1'b0;
         end
         kffpa_pkg::ST_REL_READ: begin
            tbl_cmd.rd_idx = rel_diff[IDX_W-1:0];
            pend_idx_in = rel_diff[IDX_W-1:0];
            rel_hit_in = rel_in_range;
         end
         kffpa_pkg::ST_REL_CHK: begin
            tbl_cmd.wr_idx = pend_idx_ff;
            rsp_valid_in = 1'b1;
            rsp_port_in = '0;
            rsp_reused_in = 1'b0;
            rsp_ok_in = 1'b0;
            if (rel_hit_ff && tbl_used) begin
               tbl_cmd.clr = 1'b1;
               rsp_ok_in = 1'b1;
               if (count_ff != '0) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
         kffpa_pkg::ST_RESP: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
      if (csr_we) begin
         tbl_cmd.clear_all = 1'b1;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kffpa_pkg::ST_IDLE;
         port_low_ff <= kffpa_pkg::RESET_PORT_LOW;
         port_high_ff <= kffpa_pkg::RESET_PORT_HIGH;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff <= pend_in;
         found_ff <= found_in;
         if (csr_we) begin
            unique case (csr_index)
               kffpa_pkg::CSR_PORT_LOW:  port_low_ff <= csr_wdata;
               kffpa_pkg::CSR_PORT_HIGH: port_high_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      n_ff <= n_in;
      req_id_ff <= req_id_in;
      rel_port_ff <= rel_port_in;
      issue_ff <= issue_in;
      pend_idx_ff <= pend_idx_in;
      free_idx_ff <= free_idx_in;
      rel_hit_ff <= rel_hit_in;
      rsp_port_ff <= rsp_port_in;
      rsp_ok_ff <= rsp_ok_in;
      rsp_reused_ff <= rsp_reused_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_granted_port = rsp_port_ff;
   assign rsp_ok = rsp_ok_ff;
   assign rsp_reused = rsp_reused_ff;
   assign rsp_ports_in_use = (count_ff > CNT_W'(255)) ? 8'd255 : count_ff[7:0];

endmodule

// ===== src/keyed_first_fit_port_allocator_top.sv =====
// Top level of the keyed first-fit port allocator: sequencer plus slot table.
// Depends on kffpa_pkg, kffpa_slot_table and kffpa_ctl.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/ready    mode, requester_id, release_port
//   rsp      out        rsp_valid/ready    granted_port, ok, reused, ports_in_use
//   csr      in         csr_we             csr_index, csr_wdata
//
// Allocate scans the n active slots, n at most MAX_PORTS, reading one slot per cycle
// from the slot table, then marks the first free slot it found, if there is one; a
// reuse hit ends the scan early. Release reads the slot, then checks and clears it.
// req_ready is low from a transfer until its result transfers. Reset and any range write free all slots at once.
module keyed_first_fit_port_allocator_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_mode,
   input  logic [kffpa_pkg::ID_W-1:0]      req_requester_id,
   input  logic [kffpa_pkg::PORT_W-1:0]    req_release_port,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [kffpa_pkg::PORT_W-1:0]    rsp_granted_port,
   output logic                            rsp_ok,
   output logic                            rsp_reused,
   output logic [7:0]                      rsp_ports_in_use,
   input  logic                            csr_we,
   input  logic [kffpa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [kffpa_pkg::PORT_W-1:0]    csr_wdata
);

   kffpa_pkg::tbl_cmd_type     tbl_cmd;
   logic                       tbl_used;
   logic [kffpa_pkg::ID_W-1:0] tbl_owner;

   kffpa_ctl u_ctl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_requester_id (req_requester_id),
      .req_release_port (req_release_port),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_granted_port (rsp_granted_port),
      .rsp_ok           (rsp_ok),
      .rsp_reused       (rsp_reused),
      .rsp_ports_in_use (rsp_ports_in_use),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .tbl_cmd          (tbl_cmd),
      .tbl_used         (tbl_used),
      .tbl_owner        (tbl_owner)
   );

   kffpa_slot_table u_table (
      .clock    (clock),
      .reset    (reset),
      .cmd      (tbl_cmd),
      .rd_used  (tbl_used),
      .rd_owner (tbl_owner)
   );

endmodule

// ===== src/kffpa_checker.sv =====
// Port-level checks for the keyed first-fit port allocator.
// Bound to keyed_first_fit_port_allocator_top; depends on kffpa_pkg.
module kffpa_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [kffpa_pkg::PORT_W-1:0] rsp_granted_port,
   input logic                         rsp_ok,
   input logic                         rsp_reused
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_granted_port))
      else $error("result changed while stalled");

   a_reuse_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_reused || rsp_ok))
      else $error("reused result without ok");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_granted_port == '0)
      else $error("failed result with nonzero port");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

endmodule

bind keyed_first_fit_port_allocator_top kffpa_checker u_kffpa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_granted_port (rsp_granted_port),
   .rsp_ok           (rsp_ok),
   .rsp_reused       (rsp_reused)
);

// ===== tb/tb.sv =====
// Self-checking testbench for keyed_first_fit_port_allocator_top: directed and random
// allocate/release traffic with a cycle-free slot-table predictor and random stalls.
// Depends on kffpa_pkg and the allocator RTL.
module tb;

   localparam int MAX_GAP = 12;
   localparam int TAIL_CYCLES = kffpa_pkg::MAX_PORTS + 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int STALL_HOLD = 300;

   typedef struct packed {
      logic [kffpa_pkg::PORT_W-1:0] port;
      logic                         ok;
      logic                         reused;
      logic [7:0]                   in_use;
   } grant_type;

   logic                            clock;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic                            req_mode = kffpa_pkg::MODE_ALLOC;
   logic [kffpa_pkg::ID_W-1:0]      req_requester_id = '0;
   logic [kffpa_pkg::PORT_W-1:0]    req_release_port = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [kffpa_pkg::PORT_W-1:0]    rsp_granted_port;
   logic                            rsp_ok;
   logic                            rsp_reused;
   logic [7:0]                      rsp_ports_in_use;
   logic                            csr_we = 1'b0;
   logic [kffpa_pkg::CSR_IDX_W-1:0] csr_index = kffpa_pkg::CSR_PORT_LOW;
   logic [kffpa_pkg::PORT_W-1:0]    csr_wdata = '0;

   bit                           slot_busy [kffpa_pkg::MAX_PORTS];
   logic [kffpa_pkg::ID_W-1:0]   slot_id [kffpa_pkg::MAX_PORTS];
   int                           busy_count;
   logic [kffpa_pkg::PORT_W-1:0] low_reg;
   logic [kffpa_pkg::PORT_W-1:0] high_reg;
   grant_type                    pending_grants [$];
   logic [kffpa_pkg::ID_W-1:0]   id_pool [8];
   int                           err_count = 0;
   bit                           req_gaps_on = 1'b1;
   bit                           rsp_gaps_on = 1'b1;
   int                           rsp_hold = 0;

   keyed_first_fit_port_allocator_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_requester_id (req_requester_id),
      .req_release_port (req_release_port),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_granted_port (rsp_granted_port),
      .rsp_ok           (rsp_ok),
      .rsp_reused       (rsp_reused),
      .rsp_ports_in_use (rsp_ports_in_use),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int first_port();
      return (low_reg == '0) ? 1 : int'(low_reg);
   endfunction

   function automatic int slot_span();
      int lo;
      int n;
      lo = first_port();
      if (int'(high_reg) < lo) return 0;
      n = int'(high_reg) - lo + 1;
      return (n > kffpa_pkg::MAX_PORTS) ? kffpa_pkg::MAX_PORTS : n;
   endfunction

   function automatic void clear_slots();
      foreach (slot_busy[i]) slot_busy[i] = 1'b0;
      busy_count = 0;
   endfunction

   function automatic grant_type predict_grant(logic mode, logic [kffpa_pkg::ID_W-1:0] id,
                                               logic [kffpa_pkg::PORT_W-1:0] rport);
      grant_type g;
      int lo;
      int n;
      int hit;
      g = '0;
      lo = first_port();
      n = slot_span();
      hit = -1;
      if (mode == kffpa_pkg::MODE_ALLOC) begin
         for (int i = 0; i < n && hit < 0; i++)
            if (slot_busy[i] && slot_id[i] == id) hit = i;
         if (hit >= 0) begin
            g.port = kffpa_pkg::PORT_W'(lo + hit);
            g.ok = 1'b1;
            g.reused = 1'b1;
         end else begin
            for (int i = 0; i < n && hit < 0; i++)
               if (!slot_busy[i]) hit = i;
            if (hit >= 0) begin
               slot_busy[hit] = 1'b1;
               slot_id[hit] = id;
               busy_count++;
               g.port = kffpa_pkg::PORT_W'(lo + hit);
               g.ok = 1'b1;
            end
         end
      end else if (int'(rport) >= lo && int'(rport) - lo < n) begin
         if (slot_busy[int'(rport) - lo]) begin
            slot_busy[int'(rport) - lo] = 1'b0;
            if (busy_count > 0) busy_count--;
            g.ok = 1'b1;
         end
      end
      g.in_use = (busy_count > 255) ? 8'd255 : 8'(busy_count);
      return g;
   endfunction

   function automatic void flag_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         err_count++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   task automatic send_item(logic mode, logic [kffpa_pkg::ID_W-1:0] id,
                            logic [kffpa_pkg::PORT_W-1:0] rport);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_requester_id <= id;
      req_release_port <= rport;
      do @(posedge clock); while (req_ready !== 1'b1);
      pending_grants.push_back(predict_grant(mode, id, rport));
   endtask

   task automatic wait_for_results();
      if (req_valid) req_valid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_range_reg(logic [kffpa_pkg::CSR_IDX_W-1:0] idx,
                                  logic [kffpa_pkg::PORT_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx == kffpa_pkg::CSR_PORT_LOW) low_reg = value;
      else high_reg = value;
      clear_slots();
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_range(logic [kffpa_pkg::PORT_W-1:0] lo,
                            logic [kffpa_pkg::PORT_W-1:0] hi);
      wait_for_results();
      write_range_reg(kffpa_pkg::CSR_PORT_LOW, lo);
      write_range_reg(kffpa_pkg::CSR_PORT_HIGH, hi);
   endtask

   task automatic test_default_range();
      send_item(kffpa_pkg::MODE_ALLOC, 32'h0000_0000, 16'h0000);
      send_item(kffpa_pkg::MODE_ALLOC, 32'hFFFF_FFFF, 16'hFFFF);
      send_item(kffpa_pkg::MODE_ALLOC, 32'h0000_0000, 16'h0000);
      send_item(kffpa_pkg::MODE_RELEASE, 32'h0000_0000, 16'd8201);
      send_item(kffpa_pkg::MODE_RELEASE, 32'hFFFF_FFFF, 16'd8201);
      send_item(kffpa_pkg::MODE_RELEASE, 32'h0000_0000, 16'h0000);
      send_item(kffpa_pkg::MODE_RELEASE, 32'h0000_0000, 16'hFFFF);
      send_item(kffpa_pkg::MODE_RELEASE, 32'h0000_0000, 16'd8300);
      send_item(kffpa_pkg::MODE_ALLOC, 32'h1234_5678, 16'h0000);
      send_item(kffpa_pkg::MODE_RELEASE, 32'h0000_0000, 16'd8202);
   endtask

   task automatic test_range_edges();
      set_range(16'd0, 16'd3);
      send_item(kffpa_pkg::MODE_ALLOC, 32'hA5A5_A5A5, 16'h0000);
      send_item(kffpa_pkg::MODE_ALLOC, 32'h5A5A_5A5A, 16'h0000);
      send_item(kffpa_pkg::MODE_ALLOC, 32'h0000_0001, 16'h0000);
      send_item(kffpa_pkg::MODE_ALLOC, 32'h0000_0002, 16'h0000);
      send_item(kffpa_pkg::MODE_ALLOC, 32'h5A5A_5A5A, 16'h0000);
      send_item(kffpa_pkg::MODE_RELEASE, 32'h0000_0000, 16'd0);
      send_item(kffpa_pkg::MODE_RELEASE, 32'h0000_0000, 16'd3);
      set_range(16'hFFFF, 16'hFFFF);
      send_item(kffpa_pkg::MODE_ALLOC, 32'h0000_0007, 16'h0000);
      send_item(kffpa_pkg::MODE_RELEASE, 32'h0000_0000, 16'hFFFF);
      set_range(16'd100, 16'd50);
      send_item(kffpa_pkg::MODE_ALLOC, 32'h0000_0009, 16'h0000);
      send_item(kffpa_pkg::MODE_RELEASE, 32'h0000_0000, 16'd100);
   endtask

   task automatic test_output_stall();
      set_range(16'd40, 16'd43);
      rsp_hold = STALL_HOLD;
      repeat (6) send_item(kffpa_pkg::MODE_ALLOC, $urandom, kffpa_pkg::PORT_W'($urandom));
   endtask

   task automatic run_phase(logic [kffpa_pkg::PORT_W-1:0] lo_set,
                            logic [kffpa_pkg::PORT_W-1:0] hi_set,
                            int items, int alloc_pct, int fresh_pct);
      int lo;
      int n;
      logic [kffpa_pkg::ID_W-1:0] id;
      logic [kffpa_pkg::PORT_W-1:0] port;
      set_range(lo_set, hi_set);
      foreach (id_pool[i]) id_pool[i] = $urandom;
      id_pool[0] = 32'h0000_0000;
      id_pool[1] = 32'hFFFF_FFFF;
      for (int k = 0; k < items; k++) begin
         if (k % 32 == 0) begin
            req_gaps_on = ($urandom_range(0, 3) != 0);
            rsp_gaps_on = ($urandom_range(0, 3) != 0);
         end
         lo = first_port();
         n = slot_span();
         if ($urandom_range(1, 100) <= alloc_pct) begin
            id = ($urandom_range(1, 100) <= fresh_pct) ? $urandom : id_pool[$urandom_range(0, 7)];
            send_item(kffpa_pkg::MODE_ALLOC, id, kffpa_pkg::PORT_W'($urandom));
         end else begin
            if ($urandom_range(1, 100) <= 85)
               port = kffpa_pkg::PORT_W'(lo - 1 + $urandom_range(0, n + 1));
            else port = kffpa_pkg::PORT_W'($urandom);
            send_item(kffpa_pkg::MODE_RELEASE, $urandom, port);
         end
      end
   endtask

   task automatic test_random_mix();
      logic [kffpa_pkg::PORT_W-1:0] base;
      run_phase(kffpa_pkg::RESET_PORT_LOW, kffpa_pkg::RESET_PORT_HIGH, 110, 60, 20);
      run_phase(16'd1, 16'hFFFF, 220, 90, 95);
      run_phase(16'd0, 16'd7, 100, 60, 30);
      run_phase(16'hFFFA, 16'hFFFF, 90, 60, 30);
      base = kffpa_pkg::PORT_W'($urandom_range(1, 65000));
      run_phase(base, base + kffpa_pkg::PORT_W'($urandom_range(0, 20)), 100, 60, 30);
      run_phase(16'd300, 16'd427, 100, 80, 60);
      run_phase(16'd300, 16'd428, 170, 97, 95);
      run_phase(kffpa_pkg::PORT_W'($urandom), kffpa_pkg::PORT_W'($urandom), 60, 60, 30);
   endtask

   initial begin : result_checker
      grant_type want;
      int stall;
      forever begin
         stall = (rsp_gaps_on ? $urandom_range(0, MAX_GAP) : 0) + rsp_hold;
         rsp_hold = 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (reset || rsp_valid !== 1'b1);
         if (pending_grants.size() == 0) begin
            err_count++;
            $error("result transfer with no pending request");
         end else begin
            want = pending_grants.pop_front();
            flag_field("granted_port", 32'(want.port), 32'(rsp_granted_port));
            flag_field("ok", 32'(want.ok), 32'(rsp_ok));
            flag_field("reused", 32'(want.reused), 32'(rsp_reused));
            flag_field("ports_in_use", 32'(want.in_use), 32'(rsp_ports_in_use));
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $error("no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      low_reg = kffpa_pkg::RESET_PORT_LOW;
      high_reg = kffpa_pkg::RESET_PORT_HIGH;
      clear_slots();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_default_range();
      test_range_edges();
      test_output_stall();
      test_random_mix();
      wait_for_results();
      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/kffpa_pkg.sv
src/kffpa_slot_table.sv
src/kffpa_ctl.sv
src/keyed_first_fit_port_allocator_top.sv
src/kffpa_checker.sv
tb/tb.sv
